/* rtl/wdtfs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wdtfs_pkg
// Shared codes, constants and types of the watchdog timer with feed sequence.
// ----------------------------------------------------------------------------
package wdtfs_pkg;

   // Timing constants
   localparam int PRESCALE          = 4;    // ticks per counter decrement, 1..4
   localparam int MIN_TIME_CONSTANT = 255;  // floor applied to time-constant writes

   // Transaction kinds
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // Register map
   localparam logic [2:0] REG_MODE   = 3'd0;
   localparam logic [2:0] REG_TC     = 3'd1;
   localparam logic [2:0] REG_FEED   = 3'd2;
   localparam logic [2:0] REG_TV     = 3'd3;
   localparam logic [2:0] REG_CLKSEL = 3'd4;

   // Feed bytes
   localparam logic [7:0] FEED_ARM  = 8'hAA;
   localparam logic [7:0] FEED_FIRE = 8'h55;

   // Mode register bit positions
   localparam int MOD_EN_BIT  = 0;
   localparam int MOD_RST_BIT = 1;
   localparam int MOD_TOF_BIT = 2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  reg_index;
      logic [31:0] write_data;
   } wdtfs_item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        timeout_event;
      logic        reset_request;
      logic        interrupt_level;
   } wdtfs_result_type;

endpackage : wdtfs_pkg
`default_nettype wire

/* rtl/wdtfs_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wdtfs_core
// Watchdog state and single-pass transaction logic: register access, feed
// sequence, prescaler and down counter. State commits when step is high.
// ----------------------------------------------------------------------------
module wdtfs_core #(
   parameter int PRESCALE          = wdtfs_pkg::PRESCALE,
   parameter int MIN_TIME_CONSTANT = wdtfs_pkg::MIN_TIME_CONSTANT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire wdtfs_pkg::wdtfs_item_type   item,
   output wdtfs_pkg::wdtfs_result_type      result
);
   import wdtfs_pkg::*;

   localparam logic [31:0] MIN_TC   = 32'(MIN_TIME_CONSTANT);
   localparam logic [2:0]  PRE_LAST = 3'(PRESCALE);

   logic        enable_ff,      enable_in;
   logic        rst_enable_ff,  rst_enable_in;
   logic        timeout_ff,     timeout_in;
   logic        interrupt_ff,   interrupt_in;
   logic [31:0] time_const_ff,  time_const_in;
   logic [31:0] counter_ff,     counter_in;
   logic [1:0]  prescale_ff,    prescale_in;
   logic        armed_ff,       armed_in;
   logic        running_ff,     running_in;
   logic [1:0]  clk_src_ff,     clk_src_in;

   logic [2:0]  pre_inc;
   logic        underflow;

   assign pre_inc = {1'b0, prescale_ff} + 3'd1;

   always_comb begin
      enable_in     = enable_ff;
      rst_enable_in = rst_enable_ff;
      timeout_in    = timeout_ff;
      interrupt_in  = interrupt_ff;
      time_const_in = time_const_ff;
      counter_in    = counter_ff;
      prescale_in   = prescale_ff;
      armed_in      = armed_ff;
      running_in    = running_ff;
      clk_src_in    = clk_src_ff;
      underflow     = 1'b0;
      result        = '0;

      unique case (item.mode)
         MODE_TICK: begin
            if (running_ff) begin
               if (pre_inc >= PRE_LAST) begin
                  prescale_in = 2'd0;
                  if (counter_ff == 32'd0) begin
                     underflow    = 1'b1;
                     timeout_in   = 1'b1;
                     interrupt_in = 1'b1;
                     counter_in   = time_const_ff;
                  end else begin
                     counter_in = counter_ff - 32'd1;
                  end
               end else begin
                  prescale_in = pre_inc[1:0];
               end
            end
         end
         MODE_WRITE: begin
            armed_in = 1'b0;
            unique case (item.reg_index)
               REG_FEED: begin
                  if (item.write_data[7:0] == FEED_ARM) begin
                     armed_in = 1'b1;
                  end else if (item.write_data[7:0] == FEED_FIRE && armed_ff) begin
                     counter_in  = time_const_ff;
                     prescale_in = 2'd0;
                     if (enable_ff) running_in = 1'b1;
                  end
               end
               REG_MODE: begin
                  if (item.write_data[MOD_EN_BIT])   enable_in     = 1'b1;
                  if (item.write_data[MOD_RST_BIT])  rst_enable_in = 1'b1;
                  if (!item.write_data[MOD_TOF_BIT]) timeout_in    = 1'b0;
               end
               REG_TC: begin
                  time_const_in = (item.write_data < MIN_TC) ? MIN_TC : item.write_data;
               end
               REG_CLKSEL: begin
                  clk_src_in = item.write_data[1:0];
               end
               default: ;  // counter value is read-only, others unmapped
            endcase
         end
         MODE_READ: begin
            armed_in = 1'b0;
            unique case (item.reg_index)
               REG_MODE:   result.read_data = {28'd0, interrupt_ff, timeout_ff,
                                               rst_enable_ff, enable_ff};
               REG_TC:     result.read_data = time_const_ff;
               REG_TV:     result.read_data = counter_ff;
               REG_CLKSEL: result.read_data = {30'd0, clk_src_ff};
               default:    result.read_data = 32'd0;  // feed is write-only
            endcase
         end
         default: ;  // unused transaction kind
      endcase

      result.timeout_event   = underflow;
      result.reset_request   = underflow & rst_enable_ff;
      result.interrupt_level = interrupt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         rst_enable_ff <= 1'b0;
         timeout_ff    <= 1'b0;
         interrupt_ff  <= 1'b0;
         time_const_ff <= MIN_TC;
         counter_ff    <= MIN_TC;
         prescale_ff   <= 2'd0;
         armed_ff      <= 1'b0;
         running_ff    <= 1'b0;
         clk_src_ff    <= 2'd0;
      end else if (step) begin
         enable_ff     <= enable_in;
         rst_enable_ff <= rst_enable_in;
         timeout_ff    <= timeout_in;
         interrupt_ff  <= interrupt_in;
         time_const_ff <= time_const_in;
         counter_ff    <= counter_in;
         prescale_ff   <= prescale_in;
         armed_ff      <= armed_in;
         running_ff    <= running_in;
         clk_src_ff    <= clk_src_in;
      end
   end

endmodule : wdtfs_core
`default_nettype wire

/* rtl/watchdog_timer_with_feed_sequence_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// watchdog_timer_with_feed_sequence_top
// Watchdog peripheral with a two-write feed sequence, driven by transactions.
// ----------------------------------------------------------------------------
// Each request transaction is a watchdog clock tick, a register write or a
// register read, and gives exactly one response transaction. A request is
// captured in an input register, processed by the core against the watchdog
// state, and its response lands in an output register. The block sustains
// one transaction per cycle while responses are taken. Both registers advance
// together, so a request is taken while an earlier response still waits.
// The counter reloads when a feed write of 0xAA is directly followed by one
// of 0x55 (any other read or write cancels, ticks and unused kinds do not);
// counting starts with the first valid feed after enable and decrements
// every four ticks. Underflow raises the timeout and sticky interrupt flags,
// reports a reset request if reset-enable is set, and reloads the counter.
// ----------------------------------------------------------------------------
module watchdog_timer_with_feed_sequence_top #(
   parameter int PRESCALE          = wdtfs_pkg::PRESCALE,
   parameter int MIN_TIME_CONSTANT = wdtfs_pkg::MIN_TIME_CONSTANT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [2:0]  req_reg_index,
   input  wire logic [31:0] req_write_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_read_data,
   output logic             rsp_timeout_event,
   output logic             rsp_reset_request,
   output logic             rsp_interrupt_level
);
   import wdtfs_pkg::*;

   // input stage
   logic             in_valid_ff;
   wdtfs_item_type   item_ff;

   // output stage
   logic             out_valid_ff;
   wdtfs_result_type result_ff;
   wdtfs_result_type core_result;

   logic advance;

   // The input stage moves into the output stage whenever the output stage
   // is empty or its transaction is being taken this cycle.
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   wdtfs_core #(
      .PRESCALE          (PRESCALE),
      .MIN_TIME_CONSTANT (MIN_TIME_CONSTANT)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff.mode       <= req_mode;
         item_ff.reg_index  <= req_reg_index;
         item_ff.write_data <= req_write_data;
      end
      if (advance) result_ff <= core_result;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_read_data       = result_ff.read_data;
   assign rsp_timeout_event   = result_ff.timeout_event;
   assign rsp_reset_request   = result_ff.reset_request;
   assign rsp_interrupt_level = result_ff.interrupt_level;

endmodule : watchdog_timer_with_feed_sequence_top
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the watchdog timer with feed sequence.
// ----------------------------------------------------------------------------
// Drives tick, register write and register read transactions into the
// watchdog and checks every response against an in-bench watchdog model or
// a typed-in value. A short directed table covers reset values, the
// time-constant floor, write-only and read-only registers, unmapped indices,
// the unused mode and the feed sequence corner cases. Random traffic follows:
// mostly well-formed feed sequences with random content, register traffic
// and tick bursts, plus runs of ticks long enough to underflow the counter
// with and without reset-enable. Both channels idle at random, except in a
// quiet tail at the end.
// ----------------------------------------------------------------------------
module testbench;
   import wdtfs_pkg::*;

   // Codes the package leaves out
   localparam logic [1:0] MODE_UNUSED   = 2'd3;
   localparam logic [2:0] REG_OOR_FIRST = 3'd5;
   localparam logic [2:0] REG_OOR_LAST  = 3'd7;
   localparam int         MOD_INT_BIT   = 3;

   // Run shape
   localparam int NUM_DIRECTED      = 26;
   localparam int RANDOM_ITEMS      = 850;
   localparam int QUIET_ITEMS       = 100;
   localparam int UNDERFLOWS_WANTED = 3;
   localparam int STALL_LIMIT       = 200;   // cycles with no transaction on either side
   localparam int DRAIN_CYCLES      = 8;     // margin after the last expected response

   localparam wdtfs_result_type NO_RSP = '0;

   typedef struct packed {
      logic [1:0]       mode;
      logic [2:0]       reg_index;
      logic [31:0]      write_data;
      logic             fixed;      // response typed in below, else from the model
      wdtfs_result_type rsp;
   } directed_row_type;

   // Expected responses are typed in only for reads whose value is obvious.
   localparam directed_row_type DIRECTED_ROWS [0:NUM_DIRECTED-1] = '{
      // reset values
      '{MODE_READ,  REG_MODE,      32'h0000_0000, 1'b1, '{32'd0,   1'b0, 1'b0, 1'b0}},
      '{MODE_READ,  REG_TC,        32'h0000_0000, 1'b1, '{32'd255, 1'b0, 1'b0, 1'b0}},
      '{MODE_READ,  REG_TV,        32'h0000_0000, 1'b1, '{32'd255, 1'b0, 1'b0, 1'b0}},
      // feed register is write-only, unmapped index reads zero
      '{MODE_READ,  REG_FEED,      32'hFFFF_FFFF, 1'b1, '{32'd0,   1'b0, 1'b0, 1'b0}},
      '{MODE_READ,  REG_OOR_LAST,  32'hFFFF_FFFF, 1'b1, '{32'd0,   1'b0, 1'b0, 1'b0}},
      // time constant floor and full-scale value
      '{MODE_WRITE, REG_TC,        32'h0000_0000, 1'b0, NO_RSP},
      '{MODE_READ,  REG_TC,        32'h0000_0000, 1'b1, '{32'd255, 1'b0, 1'b0, 1'b0}},
      '{MODE_WRITE, REG_TC,        32'hFFFF_FFFF, 1'b0, NO_RSP},
      '{MODE_READ,  REG_TC,        32'h0000_0000, 1'b1,
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0}},
      // clock select keeps two bits
      '{MODE_WRITE, REG_CLKSEL,    32'hFFFF_FFFE, 1'b0, NO_RSP},
      '{MODE_READ,  REG_CLKSEL,    32'h0000_0000, 1'b1, '{32'd2,   1'b0, 1'b0, 1'b0}},
      // counter value is read-only
      '{MODE_WRITE, REG_TV,        32'h0000_0000, 1'b0, NO_RSP},
      // feed while disabled reloads but does not start counting
      '{MODE_WRITE, REG_FEED,      32'h0000_00AA, 1'b0, NO_RSP},
      '{MODE_WRITE, REG_FEED,      32'h0000_0055, 1'b0, NO_RSP},
      '{MODE_READ,  REG_TV,        32'h0000_0000, 1'b0, NO_RSP},
      '{MODE_TICK,  REG_MODE,      32'hFFFF_FFFF, 1'b0, NO_RSP},
      // enable, clear timeout, upper bits ignored
      '{MODE_WRITE, REG_MODE,      32'hFFFF_FFF1, 1'b0, NO_RSP},
      // arm, re-arm, unused mode and tick keep the sequence armed
      '{MODE_WRITE, REG_FEED,      32'h1234_56AA, 1'b0, NO_RSP},
      '{MODE_WRITE, REG_FEED,      32'hFFFF_FFAA, 1'b0, NO_RSP},
      '{MODE_UNUSED, REG_FEED,     32'h0000_0055, 1'b0, NO_RSP},
      '{MODE_TICK,  REG_FEED,      32'h0000_0000, 1'b0, NO_RSP},
      '{MODE_WRITE, REG_FEED,      32'hABCD_EF55, 1'b0, NO_RSP},
      '{MODE_READ,  REG_MODE,      32'h0000_0000, 1'b0, NO_RSP},
      // an unmapped write cancels the sequence, fire without arm
      '{MODE_WRITE, REG_FEED,      32'h0000_00AA, 1'b0, NO_RSP},
      '{MODE_WRITE, REG_OOR_FIRST, 32'hFFFF_FFFF, 1'b0, NO_RSP},
      '{MODE_WRITE, REG_FEED,      32'h0000_0055, 1'b0, NO_RSP}
   };

   // DUT ports, inputs all known from time zero
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic [1:0]  req_mode       = MODE_TICK;
   logic [2:0]  req_reg_index  = REG_MODE;
   logic [31:0] req_write_data = '0;
   logic        rsp_ready      = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [31:0] rsp_read_data;
   logic        rsp_timeout_event;
   logic        rsp_reset_request;
   logic        rsp_interrupt_level;

   // Watchdog model state
   logic        wd_enable, wd_rst_enable, wd_timeout, wd_irq, wd_armed, wd_running;
   logic [31:0] wd_time_const, wd_counter;
   logic [1:0]  wd_prescale, wd_clk_sel;
   int          wd_underflows;

   // Responses still owed by the DUT, oldest first
   wdtfs_result_type expected_rsp_q[$];
   wdtfs_result_type rsp_wanted;

   int items_sent  = 0;
   int mismatches  = 0;
   int ready_hold  = 0;
   int idle_cycles = 0;
   bit no_idle     = 1'b0;   // set for the quiet tail of the run

   watchdog_timer_with_feed_sequence_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_reg_index       (req_reg_index),
      .req_write_data      (req_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_read_data       (rsp_read_data),
      .rsp_timeout_event   (rsp_timeout_event),
      .rsp_reset_request   (rsp_reset_request),
      .rsp_interrupt_level (rsp_interrupt_level)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Model: applies one accepted transaction and returns its response.
   // ------------------------------------------------------------------------
   task automatic watchdog_predict(input logic [1:0] mode, input logic [2:0] idx,
                                   input logic [31:0] data,
                                   output wdtfs_result_type rsp);
      logic [31:0] rd;
      logic        tev;
      logic        rreq;
      rd   = '0;
      tev  = 1'b0;
      rreq = 1'b0;
      case (mode)
         MODE_TICK: begin
            // ticks only count once running, one decrement per PRESCALE ticks
            if (wd_running) begin
               if (int'(wd_prescale) + 1 >= PRESCALE) begin
                  wd_prescale = '0;
                  if (wd_counter == 0) begin
                     wd_timeout = 1'b1;
                     wd_irq     = 1'b1;
                     tev        = 1'b1;
                     rreq       = wd_rst_enable;
                     wd_counter = wd_time_const;
                     wd_underflows++;
                  end else begin
                     wd_counter = wd_counter - 32'd1;
                  end
               end else begin
                  wd_prescale = wd_prescale + 2'd1;
               end
            end
         end
         MODE_WRITE: begin
            if (idx == REG_FEED) begin
               // only the low byte matters
               if (data[7:0] == FEED_ARM) begin
                  wd_armed = 1'b1;
               end else if (data[7:0] == FEED_FIRE && wd_armed) begin
                  wd_counter  = wd_time_const;
                  wd_prescale = '0;
                  wd_armed    = 1'b0;
                  if (wd_enable) wd_running = 1'b1;
               end else begin
                  wd_armed = 1'b0;
               end
            end else begin
               wd_armed = 1'b0;
               case (idx)
                  REG_MODE: begin
                     // enable bits set-only, timeout cleared by writing 0
                     if (data[MOD_EN_BIT]) wd_enable = 1'b1;
                     if (data[MOD_RST_BIT]) wd_rst_enable = 1'b1;
                     if (!data[MOD_TOF_BIT]) wd_timeout = 1'b0;
                  end
                  REG_TC: begin
                     wd_time_const = (data < 32'(MIN_TIME_CONSTANT)) ?
                                     32'(MIN_TIME_CONSTANT) : data;
                  end
                  REG_CLKSEL: wd_clk_sel = data[1:0];
                  default: ;
               endcase
            end
         end
         MODE_READ: begin
            wd_armed = 1'b0;
            case (idx)
               REG_MODE: begin
                  rd[MOD_EN_BIT]  = wd_enable;
                  rd[MOD_RST_BIT] = wd_rst_enable;
                  rd[MOD_TOF_BIT] = wd_timeout;
                  rd[MOD_INT_BIT] = wd_irq;
               end
               REG_TC:     rd = wd_time_const;
               REG_TV:     rd = wd_counter;
               REG_CLKSEL: rd = {30'd0, wd_clk_sel};
               default:    rd = '0;
            endcase
         end
         default: ;   // unused mode: no effect, sequence stays armed
      endcase
      rsp.read_data       = rd;
      rsp.timeout_event   = tev;
      rsp.reset_request   = rreq;
      rsp.interrupt_level = wd_irq;
   endtask

   // ------------------------------------------------------------------------
   // Request side: optional idle burst, then hold the transaction until it
   // is taken. The model runs at acceptance, so its state is always current
   // when the next transaction is chosen.
   // ------------------------------------------------------------------------
   task automatic issue(input logic [1:0] mode, input logic [2:0] idx,
                        input logic [31:0] data, input bit fixed = 1'b0,
                        input wdtfs_result_type fixed_rsp = '0);
      wdtfs_result_type predicted;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_reg_index  <= idx;
      req_write_data <= data;
      do @(posedge clock); while (!req_ready);
      watchdog_predict(mode, idx, data, predicted);
      expected_rsp_q.push_back(fixed ? fixed_rsp : predicted);
      items_sent++;
   endtask

   // Register write with data shaped per register. Reset-enable stays off
   // until the first underflow so that one is seen without a reset request.
   task automatic register_write(input logic [2:0] idx);
      logic [31:0] data;
      data = $urandom;
      if (idx == REG_TC && $urandom_range(0, 3) != 0) data = $urandom_range(0, 320);
      if (idx == REG_MODE && wd_underflows == 0) data[MOD_RST_BIT] = 1'b0;
      issue(MODE_WRITE, idx, data);
   endtask

   // Arm and fire, with random upper bytes. Ticks and unused-mode items may
   // sit in between; a broken attempt slips in an access that mostly cancels.
   task automatic feed_attempt(input bit broken);
      logic [2:0] idx;
      issue(MODE_WRITE, REG_FEED, {24'($urandom), FEED_ARM});
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 2))
            issue($urandom_range(0, 1) ? MODE_TICK : MODE_UNUSED, 3'($urandom), $urandom);
      end
      if (broken) begin
         case ($urandom_range(0, 2))
            0: issue(MODE_READ, 3'($urandom), $urandom);
            1: begin
               idx = 3'($urandom);
               if (idx == REG_FEED) idx = REG_TV;
               register_write(idx);
            end
            default: issue(MODE_WRITE, REG_FEED, $urandom);
         endcase
      end
      issue(MODE_WRITE, REG_FEED, {24'($urandom), FEED_FIRE});
   endtask

   // Enable, load a short time constant, feed, then tick through one or two
   // underflows with the odd register read mixed in.
   task automatic run_to_underflow();
      int          target;
      int          guard;
      logic [31:0] mode_data;
      target    = wd_underflows + $urandom_range(1, 2);
      mode_data = $urandom;
      mode_data[MOD_EN_BIT]  = 1'b1;
      mode_data[MOD_RST_BIT] = (wd_underflows != 0);
      issue(MODE_WRITE, REG_MODE, mode_data);
      issue(MODE_WRITE, REG_TC, $urandom_range(0, 300));
      feed_attempt(1'b0);
      guard = 0;
      while (wd_underflows < target && guard < 8000) begin
         if ($urandom_range(0, 49) == 0) issue(MODE_READ, 3'($urandom), $urandom);
         else issue(MODE_TICK, 3'($urandom), $urandom);
         guard++;
      end
      repeat ($urandom_range(0, 6)) issue(MODE_TICK, 3'($urandom), $urandom);
   endtask

   // One random chunk of traffic
   task automatic random_traffic();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         feed_attempt(pick < 5);
      end else if (pick < 50) begin
         repeat ($urandom_range(1, 16)) issue(MODE_TICK, 3'($urandom), $urandom);
      end else if (pick < 62) begin
         register_write(3'($urandom));
      end else if (pick < 80) begin
         issue(MODE_READ, 3'($urandom), $urandom);
      end else if (pick < 85) begin
         issue(MODE_UNUSED, 3'($urandom), $urandom);
      end else begin
         issue(MODE_WRITE, REG_FEED, $urandom);   // feed noise
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      // model starts from the reset state
      wd_enable     = 1'b0;
      wd_rst_enable = 1'b0;
      wd_timeout    = 1'b0;
      wd_irq        = 1'b0;
      wd_armed      = 1'b0;
      wd_running    = 1'b0;
      wd_time_const = 32'(MIN_TIME_CONSTANT);
      wd_counter    = 32'(MIN_TIME_CONSTANT);
      wd_prescale   = '0;
      wd_clk_sel    = '0;
      wd_underflows = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++)
         issue(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].reg_index,
               DIRECTED_ROWS[i].write_data, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].rsp);

      // random traffic; underflow runs land at random points, and are forced
      // once the item budget is spent and underflows are still missing
      while (items_sent < NUM_DIRECTED + RANDOM_ITEMS || wd_underflows < UNDERFLOWS_WANTED) begin
         if (wd_underflows < UNDERFLOWS_WANTED &&
             ($urandom_range(0, 59) == 0 || items_sent >= NUM_DIRECTED + RANDOM_ITEMS))
            run_to_underflow();
         else
            random_traffic();
      end

      // back-to-back tail, no idling on either side
      no_idle = 1'b1;
      repeat (QUIET_ITEMS) random_traffic();
      req_valid <= 1'b0;

      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: check each accepted transaction against the oldest
   // expectation, then decide rsp_ready for the next edge. Stalls come in
   // random bursts.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: response with nothing pending, expected none, actual %0h/%0b/%0b/%0b",
                     $time, rsp_read_data, rsp_timeout_event, rsp_reset_request,
                     rsp_interrupt_level);
            mismatches++;
         end else begin
            rsp_wanted = expected_rsp_q.pop_front();
            check_field("read_data", rsp_wanted.read_data, rsp_read_data);
            check_field("timeout_event", 32'(rsp_wanted.timeout_event),
                        32'(rsp_timeout_event));
            check_field("reset_request", 32'(rsp_wanted.reset_request),
                        32'(rsp_reset_request));
            check_field("interrupt_level", 32'(rsp_wanted.interrupt_level),
                        32'(rsp_interrupt_level));
         end
      end
      if (ready_hold > 0) begin
         ready_hold--;
         rsp_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
         ready_hold = $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Hang detector: cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d responses outstanding",
                  $time, idle_cycles, expected_rsp_q.size());
         $display("testbench: errors");
         $finish;
      end
   end

endmodule

/* watchdog_timer_with_feed_sequence_top.f */
rtl/wdtfs_pkg.sv
rtl/wdtfs_core.sv
rtl/watchdog_timer_with_feed_sequence_top.sv
bench/testbench.sv
